@@ design/bhm_pkg.sv @@
package bhm_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_HARD_CUTOFF = 3'd0;
    localparam logic [2:0] REG_SOFT_CUTOFF = 3'd1;
    localparam logic [2:0] REG_WARNING     = 3'd2;
    localparam logic [2:0] REG_SOFT_DELAY  = 3'd3;
    localparam logic [2:0] REG_WARN_DELAY  = 3'd4;
    localparam logic [2:0] REG_LOG_VSTEP   = 3'd5;
    localparam logic [2:0] REG_LOG_ISTEP   = 3'd6;
    localparam logic [2:0] REG_TELE_PERIOD = 3'd7;

    localparam logic [1:0] HEALTH_NORMAL = 2'd0;
    localparam logic [1:0] HEALTH_WARNING = 2'd1;
    localparam logic [1:0] HEALTH_SOFT = 2'd2;
    localparam logic [1:0] HEALTH_HARD = 2'd3;

    localparam logic [16:0] PCT_TOP_MV = 17'd24600;
    localparam logic [16:0] PCT_BOT_MV = 17'd20400;
    localparam logic [16:0] GATE_MV = 17'd6000;
    localparam logic [16:0] CELL_MIN_MV = 17'd1000;
    localparam logic [13:0] CELL_MAX = 14'd16383;
    localparam logic signed [32:0] CHARGE_STEP_CMAH = 33'sd100;

    // Reciprocals scaled by 2^18, exact over the full operand ranges used here.
    localparam int RECIP_SHIFT = 18;
    localparam logic [15:0] RECIP_SIX = 16'd43691;
    localparam logic [12:0] RECIP_FORTY_TWO = 13'd6242;

    typedef struct packed {
        logic [16:0] hard_cutoff_mv;
        logic [16:0] soft_cutoff_mv;
        logic [16:0] warning_mv;
        logic [15:0] soft_delay_ms;
        logic [15:0] warning_delay_ms;
        logic [16:0] log_voltage_step_mv;
        logic [16:0] log_current_step_ma;
        logic [15:0] telemetry_period_ms;
    } bhm_cfg_t;

endpackage

@@ design/bhm_regs.sv @@
module bhm_regs
    import bhm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output bhm_cfg_t          cfg
);

    bhm_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign wr_en = psel && penable && pwrite;
    assign reg_index = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hard_cutoff_mv <= 17'd19200;
            cfg_reg.soft_cutoff_mv <= 17'd19800;
            cfg_reg.warning_mv <= 17'd21000;
            cfg_reg.soft_delay_ms <= 16'd3000;
            cfg_reg.warning_delay_ms <= 16'd5000;
            cfg_reg.log_voltage_step_mv <= 17'd100;
            cfg_reg.log_current_step_ma <= 17'd500;
            cfg_reg.telemetry_period_ms <= 16'd200;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_HARD_CUTOFF: cfg_reg.hard_cutoff_mv <= pwdata[16:0];
                REG_SOFT_CUTOFF: cfg_reg.soft_cutoff_mv <= pwdata[16:0];
                REG_WARNING:     cfg_reg.warning_mv <= pwdata[16:0];
                REG_SOFT_DELAY:  cfg_reg.soft_delay_ms <= pwdata[15:0];
                REG_WARN_DELAY:  cfg_reg.warning_delay_ms <= pwdata[15:0];
                REG_LOG_VSTEP:   cfg_reg.log_voltage_step_mv <= pwdata[16:0];
                REG_LOG_ISTEP:   cfg_reg.log_current_step_ma <= pwdata[16:0];
                REG_TELE_PERIOD: cfg_reg.telemetry_period_ms <= pwdata[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_HARD_CUTOFF: prdata = {15'd0, cfg_reg.hard_cutoff_mv};
            REG_SOFT_CUTOFF: prdata = {15'd0, cfg_reg.soft_cutoff_mv};
            REG_WARNING:     prdata = {15'd0, cfg_reg.warning_mv};
            REG_SOFT_DELAY:  prdata = {16'd0, cfg_reg.soft_delay_ms};
            REG_WARN_DELAY:  prdata = {16'd0, cfg_reg.warning_delay_ms};
            REG_LOG_VSTEP:   prdata = {15'd0, cfg_reg.log_voltage_step_mv};
            REG_LOG_ISTEP:   prdata = {15'd0, cfg_reg.log_current_step_ma};
            REG_TELE_PERIOD: prdata = {16'd0, cfg_reg.telemetry_period_ms};
            default:         prdata = '0;
        endcase
    end

endmodule

@@ design/battery_health_monitor.sv @@
// Battery health monitor. Each accepted request is one battery sample and
// produces exactly one result, delivered in order. A sample is registered on
// acceptance, evaluated combinationally against the logged reference and
// timer state, and the result is held in an output register, so one sample
// can be accepted every clock cycle unless result_stall holds the result.
// The rate is set by the single evaluation stage, which updates the logging,
// telemetry and health state for each sample before the next is evaluated.
// The user must write thresholds, delays, log steps and the telemetry period
// over the APB port only while no sample is in flight; the block does not enforce this.
module battery_health_monitor
    import bhm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [16:0]         bus_mv,
    input  logic signed [16:0]  current_ma,
    input  logic signed [31:0]  charge_cmah,
    input  logic [31:0]         now_ms,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          health_state,
    output logic                log_record,
    output logic                telemetry_send,
    output logic [6:0]          percent_left,
    output logic [13:0]         cell_mv,
    output logic                low_battery_event
);

    bhm_cfg_t cfg;

    logic               sample_valid_reg;
    logic [16:0]        bus_reg;
    logic signed [16:0] cur_reg;
    logic signed [31:0] chg_reg;
    logic [31:0]        now_reg;

    logic               result_valid_reg;
    logic [1:0]         health_reg;
    logic               log_reg;
    logic               tele_reg;
    logic [6:0]         pct_reg;
    logic [13:0]        cell_reg;
    logic               event_reg;

    logic [16:0]        logged_mv_reg;
    logic signed [16:0] logged_ma_reg;
    logic signed [31:0] logged_charge_reg;
    logic [31:0]        telemetry_last_ms_reg;
    logic               soft_pending_reg;
    logic [31:0]        soft_start_ms_reg;
    logic               warn_pending_reg;
    logic [31:0]        warn_start_ms_reg;
    logic               warn_reported_reg;

    logic               soft_pending_next;
    logic [31:0]        soft_start_ms_next;
    logic               warn_pending_next;
    logic [31:0]        warn_start_ms_next;
    logic               warn_reported_next;

    logic               advance;
    logic               step_en;

    logic [16:0]        v_diff;
    logic signed [17:0] i_diff;
    logic [17:0]        i_abs;
    logic signed [32:0] q_diff;
    logic               log_flag;

    logic [31:0]        tele_elapsed;
    logic               tele_flag;
    logic [16:0]        pct_clamp;
    logic [16:0]        pct_span;
    logic [25:0]        pct_prod;
    logic [6:0]         pct_val;

    logic [32:0]        cell_prod;
    logic [14:0]        cell_quot;
    logic [13:0]        cell_val;

    logic [31:0]        soft_elapsed;
    logic [31:0]        warn_elapsed;
    logic               soft_done;
    logic [1:0]         health_val;
    logic               event_val;

    bhm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance = !result_valid_reg || !result_stall;
    assign step_en = sample_valid_reg && advance;
    assign sample_stall = sample_valid_reg && !advance;

    // Log trigger: voltage step, current step, or a charge rise of 1 mAh.
    assign v_diff = (bus_reg >= logged_mv_reg) ? (bus_reg - logged_mv_reg)
                                               : (logged_mv_reg - bus_reg);
    assign i_diff = {cur_reg[16], cur_reg} - {logged_ma_reg[16], logged_ma_reg};
    assign i_abs = i_diff[17] ? (18'd0 - i_diff) : i_diff;
    assign q_diff = {chg_reg[31], chg_reg} - {logged_charge_reg[31], logged_charge_reg};
    assign log_flag = (v_diff >= cfg.log_voltage_step_mv)
                   || (i_abs >= {1'b0, cfg.log_current_step_ma})
                   || (q_diff >= CHARGE_STEP_CMAH);

    assign tele_elapsed = now_reg - telemetry_last_ms_reg;
    assign tele_flag = tele_elapsed >= {16'd0, cfg.telemetry_period_ms};

    always_comb
    begin
        if (bus_reg > PCT_TOP_MV)
        begin
            pct_clamp = PCT_TOP_MV;
        end
        else if (bus_reg < PCT_BOT_MV)
        begin
            pct_clamp = PCT_BOT_MV;
        end
        else
        begin
            pct_clamp = bus_reg;
        end
    end

    // (span * 100) / 4200 equals span / 42, done as a reciprocal multiply.
    assign pct_span = pct_clamp - PCT_BOT_MV;
    assign pct_prod = pct_span[12:0] * RECIP_FORTY_TWO;
    assign pct_val = tele_flag ? pct_prod[RECIP_SHIFT+6:RECIP_SHIFT] : 7'd0;

    assign cell_prod = bus_reg * RECIP_SIX;
    assign cell_quot = cell_prod[RECIP_SHIFT+14:RECIP_SHIFT];

    always_comb
    begin
        if (bus_reg <= CELL_MIN_MV)
        begin
            cell_val = 14'd0;
        end
        else if (cell_quot > {1'b0, CELL_MAX})
        begin
            cell_val = CELL_MAX;
        end
        else
        begin
            cell_val = cell_quot[13:0];
        end
    end

    // A timer that is not yet running starts at this sample, so its elapsed time is zero.
    assign soft_elapsed = soft_pending_reg ? (now_reg - soft_start_ms_reg) : 32'd0;
    assign warn_elapsed = warn_pending_reg ? (now_reg - warn_start_ms_reg) : 32'd0;

    always_comb
    begin
        health_val = HEALTH_NORMAL;
        event_val = 1'b0;
        soft_done = 1'b0;
        soft_pending_next = soft_pending_reg;
        soft_start_ms_next = soft_start_ms_reg;
        warn_pending_next = warn_pending_reg;
        warn_start_ms_next = warn_start_ms_reg;
        warn_reported_next = warn_reported_reg;
        if (bus_reg < GATE_MV)
        begin
            soft_pending_next = 1'b0;
            warn_pending_next = 1'b0;
            warn_reported_next = 1'b0;
        end
        else if (bus_reg < cfg.hard_cutoff_mv)
        begin
            health_val = HEALTH_HARD;
        end
        else
        begin
            if (bus_reg < cfg.soft_cutoff_mv)
            begin
                soft_pending_next = 1'b1;
                if (!soft_pending_reg)
                begin
                    soft_start_ms_next = now_reg;
                end
                if (soft_elapsed >= {16'd0, cfg.soft_delay_ms})
                begin
                    health_val = HEALTH_SOFT;
                    soft_done = 1'b1;
                end
            end
            else
            begin
                soft_pending_next = 1'b0;
            end
            if (!soft_done)
            begin
                if (bus_reg < cfg.warning_mv)
                begin
                    warn_pending_next = 1'b1;
                    if (!warn_pending_reg)
                    begin
                        warn_start_ms_next = now_reg;
                    end
                    if (warn_elapsed >= {16'd0, cfg.warning_delay_ms})
                    begin
                        health_val = HEALTH_WARNING;
                        warn_reported_next = 1'b1;
                        event_val = !warn_reported_reg;
                    end
                end
                else
                begin
                    warn_pending_next = 1'b0;
                    warn_reported_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            sample_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            bus_reg <= bus_mv;
            cur_reg <= current_ma;
            chg_reg <= charge_cmah;
            now_reg <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= sample_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            health_reg <= health_val;
            log_reg <= log_flag;
            tele_reg <= tele_flag;
            pct_reg <= pct_val;
            cell_reg <= cell_val;
            event_reg <= event_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logged_mv_reg <= '0;
            logged_ma_reg <= '0;
            logged_charge_reg <= '0;
            telemetry_last_ms_reg <= '0;
            soft_pending_reg <= 1'b0;
            soft_start_ms_reg <= '0;
            warn_pending_reg <= 1'b0;
            warn_start_ms_reg <= '0;
            warn_reported_reg <= 1'b0;
        end
        else if (step_en)
        begin
            if (log_flag)
            begin
                logged_mv_reg <= bus_reg;
                logged_ma_reg <= cur_reg;
                logged_charge_reg <= chg_reg;
            end
            if (tele_flag)
            begin
                telemetry_last_ms_reg <= now_reg;
            end
            soft_pending_reg <= soft_pending_next;
            soft_start_ms_reg <= soft_start_ms_next;
            warn_pending_reg <= warn_pending_next;
            warn_start_ms_reg <= warn_start_ms_next;
            warn_reported_reg <= warn_reported_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign health_state = health_reg;
    assign log_record = log_reg;
    assign telemetry_send = tele_reg;
    assign percent_left = pct_reg;
    assign cell_mv = cell_reg;
    assign low_battery_event = event_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid_reg && result_stall))
        else $error("input stalled while the result register could advance");

    a_event_is_warning: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && event_reg) |-> (health_reg == HEALTH_WARNING))
        else $error("low battery event without warning health");

    a_pct_needs_tele: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !tele_reg) |-> (pct_reg == 7'd0))
        else $error("percent reported without telemetry");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_stall && !sample_valid_reg) |=> !result_valid_reg)
        else $error("result repeated after delivery");

    a_reported_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        warn_reported_reg |-> warn_pending_reg)
        else $error("warning reported without a running warning timer");

endmodule
